>>> hdl/cbm_pkg.sv
`timescale 1ns / 1ps

package cbm_pkg;

   // bank geometry
   localparam int unsigned ROM_BANK_BYTES = 16384;
   localparam int unsigned RAM_BANK_BYTES = 8192;
   localparam int unsigned ROM_OFFSET_BITS = $clog2(ROM_BANK_BYTES);
   localparam int unsigned RAM_OFFSET_BITS = $clog2(RAM_BANK_BYTES);

   // field widths
   localparam int unsigned ADDR_BITS = 16;
   localparam int unsigned DATA_BITS = 8;
   localparam int unsigned PHYS_BITS = 21;
   localparam int unsigned TARGET_BITS = 2;
   localparam int unsigned ROM_LOG2_BITS = 3;
   localparam int unsigned RAM_CODE_BITS = 2;
   localparam int unsigned LOW_BANK_BITS = 5;
   localparam int unsigned HIGH_BANK_BITS = 2;
   localparam int unsigned ROM_BANK_BITS = LOW_BANK_BITS + HIGH_BANK_BITS;
   localparam int unsigned RAM_ADDR_BITS = HIGH_BANK_BITS + RAM_OFFSET_BITS;
   localparam int unsigned CSR_INDEX_BITS = 1;
   localparam int unsigned CSR_DATA_BITS = 3;

   // bus operation codes
   localparam logic OP_READ = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // result targets
   localparam logic [TARGET_BITS-1:0] TARGET_NONE = 2'd0;
   localparam logic [TARGET_BITS-1:0] TARGET_ROM_READ = 2'd1;
   localparam logic [TARGET_BITS-1:0] TARGET_RAM_READ = 2'd2;
   localparam logic [TARGET_BITS-1:0] TARGET_RAM_WRITE = 2'd3;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROM_BANKS_LOG2 = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RAM_SIZE_CODE = 1'b1;

   // 8 KB address regions, by address[15:13]
   localparam logic [2:0] REGION_RAM_ENABLE = 3'd0;
   localparam logic [2:0] REGION_LOW_BANK = 3'd1;
   localparam logic [2:0] REGION_HIGH_BANK = 3'd2;
   localparam logic [2:0] REGION_BANK_MODE = 3'd3;
   localparam logic [2:0] REGION_RAM_WINDOW = 3'd5;

   // ram size codes
   localparam logic [RAM_CODE_BITS-1:0] RAM_NONE = 2'd0;
   localparam logic [RAM_CODE_BITS-1:0] RAM_2KB = 2'd1;
   localparam logic [RAM_CODE_BITS-1:0] RAM_8KB = 2'd2;
   localparam logic [RAM_CODE_BITS-1:0] RAM_32KB = 2'd3;

   // rom size thresholds in log2 of banks
   localparam logic [ROM_LOG2_BITS-1:0] ROM_64KB = 3'd2;
   localparam logic [ROM_LOG2_BITS-1:0] ROM_128KB = 3'd3;
   localparam logic [ROM_LOG2_BITS-1:0] ROM_256KB = 3'd4;
   localparam logic [ROM_LOG2_BITS-1:0] ROM_512KB = 3'd5;

   localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
   localparam logic [DATA_BITS-1:0] OPEN_BUS_DATA = 8'hFF;

   // one bus access
   typedef struct packed {
      logic                 operation;
      logic [ADDR_BITS-1:0] address;
      logic [DATA_BITS-1:0] write_data;
   } access_type;

   // one result word
   typedef struct packed {
      logic [TARGET_BITS-1:0] target;
      logic [PHYS_BITS-1:0]   phys_address;
      logic [DATA_BITS-1:0]   data_out;
      logic                   open_bus;
   } result_type;

   // mapper state seen by the translator
   typedef struct packed {
      logic                      ram_enabled;
      logic [LOW_BANK_BITS-1:0]  low_bank;
      logic [HIGH_BANK_BITS-1:0] high_bank;
      logic [HIGH_BANK_BITS-1:0] ram_bank_sel;
      logic                      bank_mode;
      logic [ROM_LOG2_BITS-1:0]  rom_log2;
      logic [RAM_CODE_BITS-1:0]  ram_size_code;
   } bank_state_type;

endpackage

>>> hdl/cbm_state.sv
`timescale 1ns / 1ps

module cbm_state (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [cbm_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [cbm_pkg::CSR_DATA_BITS-1:0]   csr_write_data,
   input  logic                                commit,
   input  cbm_pkg::access_type                 access,
   output cbm_pkg::bank_state_type             state
);

   logic                                 ram_enabled_ff, ram_enabled_in;
   logic [cbm_pkg::LOW_BANK_BITS-1:0]    low_bank_ff, low_bank_in;
   logic [cbm_pkg::HIGH_BANK_BITS-1:0]   high_bank_ff, high_bank_in;
   logic [cbm_pkg::HIGH_BANK_BITS-1:0]   ram_bank_sel_ff, ram_bank_sel_in;
   logic                                 bank_mode_ff, bank_mode_in;
   logic [cbm_pkg::ROM_LOG2_BITS-1:0]    rom_banks_log2_ff, rom_banks_log2_in;
   logic [cbm_pkg::RAM_CODE_BITS-1:0]    ram_size_code_ff, ram_size_code_in;
   logic [cbm_pkg::ROM_LOG2_BITS-1:0]    rom_log2;
   logic [cbm_pkg::LOW_BANK_BITS-1:0]    low_mask;
   logic [cbm_pkg::LOW_BANK_BITS-1:0]    low_field;

   // a zero rom size reads as 32 KB
   assign rom_log2 = (rom_banks_log2_ff == '0) ? 3'd1 : rom_banks_log2_ff;

   // small images drop the upper low-bank bits
   always_comb begin
      unique case (rom_log2)
         cbm_pkg::ROM_64KB:  low_mask = 5'h03;
         cbm_pkg::ROM_128KB: low_mask = 5'h07;
         cbm_pkg::ROM_256KB: low_mask = 5'h0F;
         default:            low_mask = 5'h1F;
      endcase
   end

   assign low_field = access.write_data[cbm_pkg::LOW_BANK_BITS-1:0];

   // configuration register writes
   always_comb begin
      rom_banks_log2_in = rom_banks_log2_ff;
      ram_size_code_in = ram_size_code_ff;
      if (csr_valid) begin
         unique case (csr_index)
            cbm_pkg::CSR_ROM_BANKS_LOG2: rom_banks_log2_in = csr_write_data;
            cbm_pkg::CSR_RAM_SIZE_CODE:
               ram_size_code_in = csr_write_data[cbm_pkg::RAM_CODE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // bank register writes from the bus
   always_comb begin
      ram_enabled_in = ram_enabled_ff;
      low_bank_in = low_bank_ff;
      high_bank_in = high_bank_ff;
      ram_bank_sel_in = ram_bank_sel_ff;
      bank_mode_in = bank_mode_ff;
      if (commit && access.operation == cbm_pkg::OP_WRITE) begin
         unique case (access.address[15:13])
            cbm_pkg::REGION_RAM_ENABLE: begin
               ram_enabled_in = (access.write_data[3:0] == cbm_pkg::RAM_ENABLE_KEY);
            end
            cbm_pkg::REGION_LOW_BANK: begin
               if (low_field == '0) begin
                  low_bank_in = 5'd1;
               end else begin
                  low_bank_in = low_field & low_mask;
               end
            end
            cbm_pkg::REGION_HIGH_BANK: begin
               if (!bank_mode_ff) begin
                  high_bank_in = (rom_log2 >= cbm_pkg::ROM_512KB) ?
                                 access.write_data[1:0] : 2'd0;
                  ram_bank_sel_in = 2'd0;
               end else begin
                  ram_bank_sel_in = (ram_size_code_ff == cbm_pkg::RAM_32KB) ?
                                    access.write_data[1:0] : 2'd0;
               end
            end
            cbm_pkg::REGION_BANK_MODE: begin
               if (rom_log2 > cbm_pkg::ROM_512KB ||
                   ram_size_code_ff == cbm_pkg::RAM_32KB) begin
                  bank_mode_in = access.write_data[0];
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_enabled_ff <= 1'b0;
         low_bank_ff <= 5'd1;
         high_bank_ff <= '0;
         ram_bank_sel_ff <= '0;
         bank_mode_ff <= 1'b0;
         rom_banks_log2_ff <= 3'd1;
         ram_size_code_ff <= cbm_pkg::RAM_NONE;
      end else begin
         ram_enabled_ff <= ram_enabled_in;
         low_bank_ff <= low_bank_in;
         high_bank_ff <= high_bank_in;
         ram_bank_sel_ff <= ram_bank_sel_in;
         bank_mode_ff <= bank_mode_in;
         rom_banks_log2_ff <= rom_banks_log2_in;
         ram_size_code_ff <= ram_size_code_in;
      end
   end

   assign state.ram_enabled = ram_enabled_ff;
   assign state.low_bank = low_bank_ff;
   assign state.high_bank = high_bank_ff;
   assign state.ram_bank_sel = ram_bank_sel_ff;
   assign state.bank_mode = bank_mode_ff;
   assign state.rom_log2 = rom_log2;
   assign state.ram_size_code = ram_size_code_ff;

endmodule

>>> hdl/cbm_xlate.sv
`timescale 1ns / 1ps

module cbm_xlate (
   input  cbm_pkg::access_type      access,
   input  cbm_pkg::bank_state_type  state,
   output cbm_pkg::result_type      result
);

   logic [cbm_pkg::ROM_BANK_BITS-1:0] rom_bank;
   logic [cbm_pkg::PHYS_BITS-1:0]     rom_mask;
   logic [cbm_pkg::PHYS_BITS-1:0]     rom_phys;
   logic [cbm_pkg::RAM_ADDR_BITS-1:0] ram_wrap;
   logic [cbm_pkg::RAM_ADDR_BITS-1:0] ram_phys;
   logic                              ram_ok;
   logic                              in_rom;
   logic                              in_ram;

   // rom image wraps at 16 KB << rom_log2
   assign rom_mask = cbm_pkg::PHYS_BITS'(
      (22'(1) << (5'(cbm_pkg::ROM_OFFSET_BITS) + 5'(state.rom_log2))) - 22'd1);

   // fixed window uses bank 0 or the upper bits only
   always_comb begin
      if (access.address[cbm_pkg::ROM_OFFSET_BITS]) begin
         rom_bank = {state.high_bank, state.low_bank};
      end else if (state.bank_mode) begin
         rom_bank = {state.high_bank, {cbm_pkg::LOW_BANK_BITS{1'b0}}};
      end else begin
         rom_bank = '0;
      end
   end

   assign rom_phys = {rom_bank, access.address[cbm_pkg::ROM_OFFSET_BITS-1:0]} & rom_mask;

   // ram store wraps to its size
   always_comb begin
      unique case (state.ram_size_code)
         cbm_pkg::RAM_2KB: ram_wrap = 15'h07FF;
         cbm_pkg::RAM_8KB: ram_wrap = 15'h1FFF;
         default:          ram_wrap = 15'h7FFF;
      endcase
   end

   assign ram_phys = {state.ram_bank_sel, access.address[cbm_pkg::RAM_OFFSET_BITS-1:0]}
                     & ram_wrap;

   assign ram_ok = (state.ram_size_code != cbm_pkg::RAM_NONE) && state.ram_enabled;
   assign in_rom = !access.address[15];
   assign in_ram = (access.address[15:13] == cbm_pkg::REGION_RAM_WINDOW) && ram_ok;

   // result word
   always_comb begin
      result.target = cbm_pkg::TARGET_NONE;
      result.phys_address = '0;
      result.data_out = '0;
      result.open_bus = 1'b0;
      if (access.operation == cbm_pkg::OP_WRITE) begin
         if (in_ram) begin
            result.target = cbm_pkg::TARGET_RAM_WRITE;
            result.phys_address = cbm_pkg::PHYS_BITS'(ram_phys);
            result.data_out = access.write_data;
         end
      end else begin
         priority if (in_rom) begin
            result.target = cbm_pkg::TARGET_ROM_READ;
            result.phys_address = rom_phys;
         end else if (in_ram) begin
            result.target = cbm_pkg::TARGET_RAM_READ;
            result.phys_address = cbm_pkg::PHYS_BITS'(ram_phys);
         end else begin
            result.data_out = cbm_pkg::OPEN_BUS_DATA;
            result.open_bus = 1'b1;
         end
      end
   end

endmodule

>>> hdl/cartridge_bank_mapper.sv
`timescale 1ns / 1ps

// MBC1-style cartridge bank mapper. Each bus access word (read or write of a
// 16-bit address) is taken into an input register, decoded combinationally
// against the bank registers, and its result word (target, physical byte
// address, data and open-bus flag) lands in a result register: one access per
// cycle sustained while rsp_stall is low, each access passing the input register
// and then the result register. Writes below 0x8000 update the bank registers as
// they leave the input register, so the next access already sees them. ROM and
// RAM contents are outside this block; the result only says where to go. The
// configuration port (ROM size as log2 of 16 KB banks, RAM size code) is always
// ready and should be written only while no access is in flight.
module cartridge_bank_mapper (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_operation,
   input  logic [cbm_pkg::ADDR_BITS-1:0]       req_address,
   input  logic [cbm_pkg::DATA_BITS-1:0]       req_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [cbm_pkg::TARGET_BITS-1:0]     rsp_target,
   output logic [cbm_pkg::PHYS_BITS-1:0]       rsp_phys_address,
   output logic [cbm_pkg::DATA_BITS-1:0]       rsp_data_out,
   output logic                                rsp_open_bus,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cbm_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [cbm_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);

   logic                    in_valid_ff, in_valid_in;
   cbm_pkg::access_type     in_word_ff, in_word_in;
   logic                    out_valid_ff, out_valid_in;
   cbm_pkg::result_type     out_word_ff, out_word_in;
   cbm_pkg::bank_state_type state;
   cbm_pkg::result_type     result;
   logic                    out_free;
   logic                    advance;
   logic                    req_take;

   // handshake between the two register stages
   assign out_free = !out_valid_ff || !rsp_stall;
   assign advance = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   cbm_state u_state (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .commit         (advance),
      .access         (in_word_ff),
      .state          (state)
   );

   cbm_xlate u_xlate (
      .access (in_word_ff),
      .state  (state),
      .result (result)
   );

   // input stage
   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in = in_word_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_word_in.operation = req_operation;
         in_word_in.address = req_address;
         in_word_in.write_data = req_write_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // result stage
   always_comb begin
      out_valid_in = out_valid_ff;
      out_word_in = out_word_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_word_in = result;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff <= in_word_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_target = out_word_ff.target;
   assign rsp_phys_address = out_word_ff.phys_address;
   assign rsp_data_out = out_word_ff.data_out;
   assign rsp_open_bus = out_word_ff.open_bus;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned PHASE_ACCESSES = 215;
   localparam int unsigned HOLD_CYCLES = 80;
   localparam int unsigned ROM_SWITCH_BASE = 32'h4000;
   localparam int unsigned UNMAPPED_BASE = 32'h8000;
   localparam int unsigned RAM_WINDOW_BASE = 32'hA000;

   // idle patterns
   localparam int IDLE_NONE = 0;
   localparam int IDLE_SENDER = 1;
   localparam int IDLE_RECEIVER = 2;
   localparam int IDLE_BOTH = 3;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_valid;
   logic                               req_stall;
   logic                               req_operation;
   logic [cbm_pkg::ADDR_BITS-1:0]      req_address;
   logic [cbm_pkg::DATA_BITS-1:0]      req_write_data;
   logic                               rsp_valid;
   logic                               rsp_stall;
   logic [cbm_pkg::TARGET_BITS-1:0]    rsp_target;
   logic [cbm_pkg::PHYS_BITS-1:0]      rsp_phys_address;
   logic [cbm_pkg::DATA_BITS-1:0]      rsp_data_out;
   logic                               rsp_open_bus;
   logic                               csr_valid;
   logic                               csr_ready;
   logic [cbm_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [cbm_pkg::CSR_DATA_BITS-1:0]  csr_write_data;

   // mapper state as predicted
   logic                               bank_ram_on;
   logic [cbm_pkg::LOW_BANK_BITS-1:0]  bank_low;
   logic [cbm_pkg::HIGH_BANK_BITS-1:0] bank_high;
   logic [cbm_pkg::HIGH_BANK_BITS-1:0] bank_ram_sel;
   logic                               bank_mode_sel;
   logic [cbm_pkg::ROM_LOG2_BITS-1:0]  size_rom_log2;
   logic [cbm_pkg::RAM_CODE_BITS-1:0]  size_ram_code;

   cbm_pkg::result_type pending_results[$];
   int unsigned mismatch_count = 0;
   int unsigned accesses_sent = 0;
   int unsigned results_seen = 0;
   int unsigned size_settings = 0;
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned stall_hold = 0;

   cartridge_bank_mapper dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_address      (req_address),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_target       (rsp_target),
      .rsp_phys_address (rsp_phys_address),
      .rsp_data_out     (rsp_data_out),
      .rsp_open_bus     (rsp_open_bus),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // translate one bus access and update the bank registers
   function automatic cbm_pkg::result_type map_access(
      input logic op, input logic [cbm_pkg::ADDR_BITS-1:0] addr,
      input logic [cbm_pkg::DATA_BITS-1:0] data);
      cbm_pkg::result_type               res;
      logic [cbm_pkg::ROM_LOG2_BITS-1:0] lg;
      int unsigned                       a;
      int unsigned                       k;
      int unsigned                       rom_limit;
      int unsigned                       ram_limit;
      int unsigned                       bank;
      int unsigned                       ram_phys;
      logic                              ram_ok;
      res = '0;
      a = addr;
      lg = (size_rom_log2 == '0) ? 3'd1 : size_rom_log2;
      rom_limit = (cbm_pkg::ROM_BANK_BYTES << lg) - 1;
      case (size_ram_code)
         cbm_pkg::RAM_2KB: ram_limit = 32'h7FF;
         cbm_pkg::RAM_8KB: ram_limit = 32'h1FFF;
         default:          ram_limit = 32'h7FFF;
      endcase
      ram_ok = (size_ram_code != cbm_pkg::RAM_NONE) && bank_ram_on;
      ram_phys = (bank_ram_sel * cbm_pkg::RAM_BANK_BYTES + (a - RAM_WINDOW_BASE))
                 & ram_limit;
      if (op == cbm_pkg::OP_WRITE) begin
         case (addr[15:13])
            cbm_pkg::REGION_RAM_ENABLE: begin
               bank_ram_on = (data[3:0] == cbm_pkg::RAM_ENABLE_KEY);
            end
            cbm_pkg::REGION_LOW_BANK: begin
               if (data[4:0] == '0) begin
                  bank_low = 5'd1;
               end else begin
                  // small images keep fewer low bank bits
                  case (lg)
                     cbm_pkg::ROM_64KB:  k = 3;
                     cbm_pkg::ROM_128KB: k = 2;
                     cbm_pkg::ROM_256KB: k = 1;
                     default:            k = 0;
                  endcase
                  bank_low = data[4:0] & (5'h1F >> k);
               end
            end
            cbm_pkg::REGION_HIGH_BANK: begin
               if (!bank_mode_sel) begin
                  bank_high = (lg >= cbm_pkg::ROM_512KB) ? data[1:0] : 2'd0;
                  bank_ram_sel = 2'd0;
               end else begin
                  bank_ram_sel = (size_ram_code == cbm_pkg::RAM_32KB) ? data[1:0] : 2'd0;
               end
            end
            cbm_pkg::REGION_BANK_MODE: begin
               if (lg > cbm_pkg::ROM_512KB || size_ram_code == cbm_pkg::RAM_32KB)
                  bank_mode_sel = data[0];
            end
            cbm_pkg::REGION_RAM_WINDOW: begin
               if (ram_ok) begin
                  res.target = cbm_pkg::TARGET_RAM_WRITE;
                  res.phys_address = cbm_pkg::PHYS_BITS'(ram_phys);
                  res.data_out = data;
               end
            end
            default: begin
            end
         endcase
      end else if (a < ROM_SWITCH_BASE) begin
         bank = bank_mode_sel ? {bank_high, 5'd0} : 0;
         res.target = cbm_pkg::TARGET_ROM_READ;
         res.phys_address =
            cbm_pkg::PHYS_BITS'((bank * cbm_pkg::ROM_BANK_BYTES + a) & rom_limit);
      end else if (a < UNMAPPED_BASE) begin
         bank = {bank_high, bank_low};
         res.target = cbm_pkg::TARGET_ROM_READ;
         res.phys_address = cbm_pkg::PHYS_BITS'(
            (bank * cbm_pkg::ROM_BANK_BYTES + (a - ROM_SWITCH_BASE)) & rom_limit);
      end else if (addr[15:13] == cbm_pkg::REGION_RAM_WINDOW && ram_ok) begin
         res.target = cbm_pkg::TARGET_RAM_READ;
         res.phys_address = cbm_pkg::PHYS_BITS'(ram_phys);
      end else begin
         res.data_out = cbm_pkg::OPEN_BUS_DATA;
         res.open_bus = 1'b1;
      end
      return res;
   endfunction

   // mismatch bookkeeping
   function automatic void note_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch: %s", msg);
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got)
         note_error($sformatf("word %0d %s expected %0h actual %0h", results_seen, name,
                              want, got));
   endfunction

   // result checker
   always @(posedge clock) begin : result_check
      cbm_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            note_error($sformatf("unexpected word target %0h address %0h", rsp_target,
                                 rsp_phys_address));
         end else begin
            want = pending_results.pop_front();
            check_field("target", want.target, rsp_target);
            check_field("phys_address", want.phys_address, rsp_phys_address);
            check_field("data_out", want.data_out, rsp_data_out);
            check_field("open_bus", want.open_bus, rsp_open_bus);
         end
      end
   end

   // receiver stall, with an optional long hold-off
   always @(negedge clock) begin
      if (stall_hold > 0) begin
         rsp_stall <= 1'b1;
         stall_hold = stall_hold - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // watchdog on cycles with no handshake at all
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("simulation failed");
      $finish;
   end

   // offer one access word and record its expected result
   task automatic issue_access(input logic op, input logic [cbm_pkg::ADDR_BITS-1:0] addr,
                               input logic [cbm_pkg::DATA_BITS-1:0] data);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_address <= addr;
      req_write_data <= data;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(map_access(op, addr, data));
      accesses_sent++;
      @(negedge clock);
   endtask

   // mostly well-formed traffic: control writes, rom reads, ram window, some noise
   task automatic issue_random_access();
      logic                          op;
      logic [cbm_pkg::ADDR_BITS-1:0] addr;
      logic [cbm_pkg::DATA_BITS-1:0] data;
      int unsigned                   pick;
      pick = $urandom_range(99);
      op = 1'($urandom);
      addr = 16'($urandom);
      data = 8'($urandom);
      if (pick < 30) begin
         op = cbm_pkg::OP_WRITE;
         addr[15] = 1'b0;
         if (addr[15:13] == cbm_pkg::REGION_RAM_ENABLE && $urandom_range(1))
            data[3:0] = cbm_pkg::RAM_ENABLE_KEY;
      end else if (pick < 60) begin
         op = cbm_pkg::OP_READ;
         addr[15] = 1'b0;
      end else if (pick < 85) begin
         addr[15:13] = cbm_pkg::REGION_RAM_WINDOW;
      end
      issue_access(op, addr, data);
   endtask

   // stop offering and wait for every expected word
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // offer one register write; the caller drops csr_valid afterwards
   task automatic write_csr(input logic [cbm_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [cbm_pkg::CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == cbm_pkg::CSR_ROM_BANKS_LOG2) size_rom_log2 = value;
      else size_ram_code = value[cbm_pkg::RAM_CODE_BITS-1:0];
      @(negedge clock);
   endtask

   task automatic set_sizes(input logic [cbm_pkg::CSR_DATA_BITS-1:0] rom_log2,
                            input logic [cbm_pkg::CSR_DATA_BITS-1:0] ram_code);
      drain_results();
      write_csr(cbm_pkg::CSR_ROM_BANKS_LOG2, rom_log2);
      write_csr(cbm_pkg::CSR_RAM_SIZE_CODE, ram_code);
      csr_valid <= 1'b0;
      size_settings++;
   endtask

   task automatic set_idle(input int pattern);
      case (pattern)
         IDLE_SENDER: begin
            sender_idle_pct = 52;
            receiver_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            sender_idle_pct = 0;
            receiver_stall_pct = 52;
         end
         IDLE_BOTH: begin
            sender_idle_pct = 17;
            receiver_stall_pct = 17;
         end
         default: begin
            sender_idle_pct = 0;
            receiver_stall_pct = 0;
         end
      endcase
   endtask

   // defaults after reset: 32 KB rom, no ram
   task automatic test_reset_state();
      issue_access(cbm_pkg::OP_READ, 16'h4000, 8'h00);
      issue_access(cbm_pkg::OP_READ, 16'hA000, 8'h00);
      issue_access(cbm_pkg::OP_WRITE, 16'h0000, 8'h0A);
      issue_access(cbm_pkg::OP_READ, 16'hA000, 8'h00);
   endtask

   // every control region, ram window and unmapped space on the largest sizes
   task automatic test_bank_registers();
      set_sizes(3'd7, 3'(cbm_pkg::RAM_32KB));
      issue_access(cbm_pkg::OP_WRITE, 16'h0000, 8'h0A);
      issue_access(cbm_pkg::OP_READ, 16'hA000, 8'h00);
      issue_access(cbm_pkg::OP_WRITE, 16'hBFFF, 8'hFF);
      issue_access(cbm_pkg::OP_READ, 16'hBFFF, 8'h00);
      // zero low bank selects bank 1
      issue_access(cbm_pkg::OP_WRITE, 16'h2000, 8'h00);
      issue_access(cbm_pkg::OP_READ, 16'h4000, 8'h00);
      issue_access(cbm_pkg::OP_WRITE, 16'h3FFF, 8'hFF);
      issue_access(cbm_pkg::OP_WRITE, 16'h4000, 8'h03);
      issue_access(cbm_pkg::OP_READ, 16'h7FFF, 8'h00);
      issue_access(cbm_pkg::OP_WRITE, 16'h6000, 8'h01);
      issue_access(cbm_pkg::OP_READ, 16'h0000, 8'h00);
      issue_access(cbm_pkg::OP_WRITE, 16'h5FFF, 8'h02);
      issue_access(cbm_pkg::OP_READ, 16'hA123, 8'h00);
      issue_access(cbm_pkg::OP_WRITE, 16'h7FFF, 8'h00);
      // unmapped reads and writes
      issue_access(cbm_pkg::OP_READ, 16'h8000, 8'h00);
      issue_access(cbm_pkg::OP_READ, 16'hFFFF, 8'h00);
      issue_access(cbm_pkg::OP_WRITE, 16'hC000, 8'h55);
      // disabled ram reads open bus and drops writes
      issue_access(cbm_pkg::OP_WRITE, 16'h1FFF, 8'h00);
      issue_access(cbm_pkg::OP_READ, 16'hA000, 8'h00);
      issue_access(cbm_pkg::OP_WRITE, 16'hA000, 8'h12);
   endtask

   // rom size register zero behaves as 32 KB
   task automatic test_rom_size_zero();
      set_sizes(3'd0, 3'(cbm_pkg::RAM_2KB));
      issue_access(cbm_pkg::OP_WRITE, 16'h2000, 8'h1F);
      issue_access(cbm_pkg::OP_READ, 16'h7FFF, 8'h00);
   endtask

   // random traffic across size settings and idle patterns
   task automatic test_random_phases();
      logic [cbm_pkg::CSR_DATA_BITS-1:0] rom_list[8];
      logic [cbm_pkg::CSR_DATA_BITS-1:0] ram_list[8];
      rom_list = '{3'd1, 3'd7, 3'd2, 3'd5, 3'd4, 3'd3, 3'd6, 3'd7};
      ram_list = '{3'd0, 3'd3, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2};
      for (int p = 0; p < 8; p++) begin
         set_sizes(rom_list[p], ram_list[p]);
         set_idle(p % 4);
         repeat (PHASE_ACCESSES) issue_random_access();
      end
   endtask

   // long result hold-off fills the block, then a full drain before more traffic
   task automatic test_backpressure();
      set_sizes(3'd6, 3'(cbm_pkg::RAM_32KB));
      set_idle(IDLE_NONE);
      stall_hold = HOLD_CYCLES;
      repeat (60) issue_random_access();
      drain_results();
      repeat (40) issue_random_access();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = cbm_pkg::OP_READ;
      req_address = '0;
      req_write_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = cbm_pkg::CSR_ROM_BANKS_LOG2;
      csr_write_data = '0;
      bank_ram_on = 1'b0;
      bank_low = 5'd1;
      bank_high = '0;
      bank_ram_sel = '0;
      bank_mode_sel = 1'b0;
      size_rom_log2 = 3'd1;
      size_ram_code = cbm_pkg::RAM_NONE;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_state();
      test_bank_registers();
      test_rom_size_zero();
      test_random_phases();
      test_backpressure();

      drain_results();
      repeat (8) @(posedge clock);
      $display("checked %0d bus accesses and %0d result words over %0d rom/ram size settings",
               accesses_sent, results_seen, size_settings);
      $display("traffic ran with no idling, sender gaps, receiver stalls, both, and a long hold");
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
